FILE: design/qdv_pkg.sv
`default_nettype none
package qdv_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int RING_W = $clog2(HISTORY_DEPTH + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam int ENTRIES = 2 ** ADDR_W;

  localparam int TIME_W = 32;
  localparam int CNT_W = 32;
  localparam int TICK_W = 16;
  localparam int CFG_W = 16;
  localparam int VEL_W = 48;
  localparam int NUM_W = 52;
  localparam int DEN_W = 48;
  localparam int QF_W = VEL_W - 1;
  localparam int SAT_SH = QF_W - 16;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 80;

  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] REG_RING = 2'd0;
  localparam logic [1:0] REG_LEVELS = 2'd1;
  localparam logic [1:0] REG_INVERT = 2'd2;
  localparam logic [1:0] REG_TICKS = 2'd3;

  localparam logic [4:0] RING_RESET = 5'd10;
  localparam logic [TICK_W-1:0] TICKS_RESET = 16'd1024;
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [TIME_W-1:0] TIME_STEP = 32'd10;
  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {QF_W{1'b1}}};
  localparam logic [VEL_W-1:0] VEL_SAT_MAG = {1'b1, {QF_W{1'b0}}};

  typedef struct packed {
    logic [CNT_W-1:0] magc;
    logic [TIME_W-1:0] magt;
    logic [TICK_W-1:0] ticks;
    logic neg;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [VEL_W-1:0] vel;
  } div_resp_t;

  function automatic logic [RING_W-1:0] ring_clamp(logic [4:0] v);
    logic [RING_W-1:0] n;
    if (v < 5'd2) n = RING_W'(2);
    else if (int'(v) > HISTORY_DEPTH) n = RING_W'(HISTORY_DEPTH);
    else n = RING_W'(v);
    return n;
  endfunction

  function automatic logic [IDX_W-1:0] ring_adv(logic [IDX_W-1:0] idx,
                                                logic [RING_W-1:0] n);
    logic [RING_W-1:0] nxt;
    nxt = RING_W'(idx) + RING_W'(1);
    return (nxt >= n) ? '0 : IDX_W'(nxt);
  endfunction

endpackage
`default_nettype wire

FILE: design/qdv_ram.sv
`default_nettype none
module qdv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/qdv_div.sv
`default_nettype none
module qdv_div
  import qdv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire div_req_t  req,
  output      div_resp_t resp
);

  typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_FIN} dstate_t;

  dstate_t state;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [QF_W-1:0] dsh;
  logic [QF_W-1:0] quo;
  logic [$clog2(QF_W)-1:0] cnt;
  logic neg;
  logic ovf;
  logic done;
  logic [VEL_W-1:0] vel;

  logic [DEN_W-1:0] trial;
  logic ge;
  logic [VEL_W-1:0] mag;

  always_comb begin
    trial = {rem[DEN_W-2:0], dsh[QF_W-1]};
    ge = trial >= den;
    mag = ovf ? VEL_SAT_MAG : {1'b0, quo};
    resp.done = done;
    resp.vel = vel;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            num <= NUM_W'(req.magc) * NUM_W'(US_PER_S);
            den <= DEN_W'(req.magt) * DEN_W'(req.ticks);
            neg <= req.neg;
            state <= D_CHK;
          end
        end
        D_CHK: begin
          ovf <= (DEN_W + SAT_SH)'(num) >= {den, {SAT_SH{1'b0}}};
          rem <= DEN_W'(num >> SAT_SH);
          dsh <= {num[SAT_SH-1:0], 16'd0};
          quo <= '0;
          cnt <= ($clog2(QF_W))'(QF_W - 1);
          if ((DEN_W + SAT_SH)'(num) >= {den, {SAT_SH{1'b0}}}) state <= D_FIN;
          else state <= D_RUN;
        end
        D_RUN: begin
          rem <= ge ? trial - den : trial;
          quo <= {quo[QF_W-2:0], ge};
          dsh <= {dsh[QF_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) state <= D_FIN;
        end
        D_FIN: begin
          vel <= neg ? VEL_W'(0) - mag : (ovf ? VEL_MAX : mag);
          done <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/quadrature_decoder_with_velocity.sv
`default_nettype none
// Channel  Dir  Signals                      Content
// s        in   s_tvalid/s_tready/s_tdata    wheel, line, reset_mask, now_us
//               s_tuser                      op
// m        out  m_tvalid/m_tready/m_tdata    position_count, velocity_q16
//               m_tuser                      stale
// cfg      in   cfg_we/cfg_index/cfg_data    register write, no read-back
//
// Edge, clear and unused ops go from accept to the output state, which waits for a free output.
// Query: two history memory reads, one multiply stage, one range check and the 47-step
// restoring divider; overflow, stale and zero-span queries skip the divide steps.
// One item in flight; a finished result waits in the output register.
// Reset needs no clearing pass: per-entry valid bits stand for reset history.
module quadrature_decoder_with_velocity
  import qdv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output      logic                s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // wheel, line, reset_mask[1:0], now_us[31:0]
  input  wire logic [1:0]          s_tuser,   // op[1:0]
  output      logic                m_tvalid,
  input  wire logic                m_tready,
  output      logic [M_DATA_W-1:0] m_tdata,   // position_count[31:0], velocity_q16[47:0]
  output      logic                m_tuser,   // stale
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_TAIL, S_DIV, S_OUT} state_t;

  state_t state;
  logic [RING_W-1:0] ring_n;
  logic [3:0] line_levels;
  logic [1:0] invert;
  logic [TICK_W-1:0] ticks;
  logic [CNT_W-1:0] counts [2];
  logic [IDX_W-1:0] head_idx [2];
  logic [IDX_W-1:0] tail_idx [2];
  logic [ENTRIES-1:0] vld;
  logic wheel_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] head_time;
  logic [CNT_W-1:0] head_cnt;
  logic rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [VEL_W-1:0] res_vel;
  logic res_stale;
  logic div_start;
  div_req_t div_req;
  div_resp_t div_resp;

  logic [1:0] in_op;
  logic in_wheel;
  logic in_line;
  logic [1:0] in_rm;
  logic [TIME_W-1:0] in_now;
  logic accept;
  logic [3:0] lv_next;
  logic lv_a;
  logic lv_b;
  logic up;
  logic [CNT_W-1:0] cnt_next;
  logic [IDX_W-1:0] h_next;
  logic wr_en;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [TIME_W-1:0] tram_q;
  logic [CNT_W-1:0] cram_q;
  logic [TIME_W-1:0] eff_time;
  logic [CNT_W-1:0] eff_cnt;
  logic [TIME_W-1:0] span;
  logic [TIME_W-1:0] elapsed;
  logic is_stale;
  logic [CNT_W-1:0] dc;
  logic out_free;

  always_comb begin
    in_op = s_tuser;
    in_wheel = s_tdata[0];
    in_line = s_tdata[1];
    in_rm = s_tdata[3:2];
    in_now = s_tdata[35:4];
    s_tready = (state == S_IDLE);
    accept = s_tvalid && s_tready;

    lv_next = line_levels ^ (4'b0001 << {in_wheel, in_line});
    lv_a = lv_next[{in_wheel, 1'b0}];
    lv_b = lv_next[{in_wheel, 1'b1}];
    up = in_line ? (lv_a != lv_b) : (lv_a == lv_b);
    cnt_next = counts[in_wheel] + (up ? CNT_W'(1) : {CNT_W{1'b1}});
    h_next = ring_adv(head_idx[in_wheel], ring_n);

    wr_en = accept && (in_op == OP_EDGE);
    waddr = {in_wheel, h_next};
    raddr = (state == S_HEAD) ? {wheel_q, tail_idx[wheel_q]}
                              : {in_wheel, head_idx[in_wheel]};

    eff_time = rd_vld ? tram_q : TIME_W'(rd_idx) * TIME_STEP;
    eff_cnt = rd_vld ? cram_q : '0;
    span = head_time - eff_time;
    elapsed = now_q - head_time;
    is_stale = elapsed > {span[TIME_W-2:0], 1'b0};
    dc = head_cnt - eff_cnt;
    out_free = !m_tvalid || m_tready;
  end

  qdv_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_time_ram (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata(in_now),
    .raddr(raddr), .rdata(tram_q)
  );

  qdv_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_count_ram (
    .clk(clk), .we(wr_en), .waddr(waddr), .wdata(cnt_next),
    .raddr(raddr), .rdata(cram_q)
  );

  qdv_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .req(div_req), .resp(div_resp)
  );

  always_ff @(posedge clk) begin
    rd_vld <= vld[raddr];
    rd_idx <= raddr[IDX_W-1:0];
    div_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      ring_n <= ring_clamp(RING_RESET);
      line_levels <= '0;
      invert <= '0;
      ticks <= TICKS_RESET;
      counts[0] <= '0;
      counts[1] <= '0;
      head_idx[0] <= IDX_W'(ring_clamp(RING_RESET) - 1'b1);
      head_idx[1] <= IDX_W'(ring_clamp(RING_RESET) - 1'b1);
      tail_idx[0] <= '0;
      tail_idx[1] <= '0;
      vld <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            wheel_q <= in_wheel;
            now_q <= in_now;
            res_vel <= '0;
            res_stale <= 1'b0;
            case (in_op)
              OP_EDGE: begin
                line_levels <= lv_next;
                counts[in_wheel] <= cnt_next;
                head_idx[in_wheel] <= h_next;
                tail_idx[in_wheel] <= ring_adv(tail_idx[in_wheel], ring_n);
                vld[waddr] <= 1'b1;
                state <= S_OUT;
              end
              OP_QUERY: state <= S_HEAD;
              OP_CLEAR: begin
                if (in_rm[0]) counts[0] <= '0;
                if (in_rm[1]) counts[1] <= '0;
                state <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_HEAD: begin
          head_time <= eff_time;
          head_cnt <= eff_cnt;
          state <= S_TAIL;
        end
        S_TAIL: begin
          if (is_stale) begin
            res_stale <= 1'b1;
            state <= S_OUT;
          end else if (span == '0) begin
            state <= S_OUT;
          end else begin
            div_req.magc <= dc[CNT_W-1] ? CNT_W'(0) - dc : dc;
            div_req.magt <= span[TIME_W-1] ? TIME_W'(0) - span : span;
            div_req.ticks <= (ticks == '0) ? TICK_W'(1) : ticks;
            div_req.neg <= dc[CNT_W-1] ^ span[TIME_W-1] ^ invert[wheel_q];
            div_start <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_resp.done) begin
            res_vel <= div_resp.vel;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= {res_vel, counts[wheel_q]};
            m_tuser <= res_stale;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          REG_RING: begin
            ring_n <= ring_clamp(cfg_data[4:0]);
            head_idx[0] <= IDX_W'(ring_clamp(cfg_data[4:0]) - 1'b1);
            head_idx[1] <= IDX_W'(ring_clamp(cfg_data[4:0]) - 1'b1);
            tail_idx[0] <= '0;
            tail_idx[1] <= '0;
            vld <= '0;
          end
          REG_LEVELS: line_levels <= cfg_data[3:0];
          REG_INVERT: invert <= cfg_data[1:0];
          REG_TICKS: ticks <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  a_ring_left: assert property (@(posedge clk) disable iff (rst)
    tail_idx[0] == ring_adv(head_idx[0], ring_n))
    else $error("left ring tail does not follow head");

  a_ring_right: assert property (@(posedge clk) disable iff (rst)
    tail_idx[1] == ring_adv(head_idx[1], ring_n))
    else $error("right ring tail does not follow head");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    RING_W'(head_idx[0]) < ring_n && RING_W'(head_idx[1]) < ring_n)
    else $error("head index beyond ring size");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> state == S_DIV)
    else $error("divider result outside query wait");

  a_stale_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[M_DATA_W-1:CNT_W] == '0)
    else $error("stale item carries nonzero velocity");

endmodule
`default_nettype wire
